### rtl/frustum_sphere_cull_top_macros.svh
`ifndef FRUSTUM_SPHERE_CULL_TOP_MACROS_SVH
`define FRUSTUM_SPHERE_CULL_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define FSC_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frustum cull check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define FSC_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frustum cull check failed");

`endif

### rtl/fsc_pkg.sv
`default_nettype none
package fsc_pkg;
	localparam int WORD_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_COLS      = 4;
	localparam int NUM_PLANES    = 6;
	localparam int SQ_STEPS      = 32;

	localparam logic       OP_LOAD  = 1'b0;
	localparam logic       OP_TEST  = 1'b1;
	localparam logic [1:0] COL_LAST = 2'd3;

	localparam logic [WORD_W-1:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] S32_MIN = 32'h8000_0000;

	function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] n;
		n = 32'(~v + 32'd1);
		return v[WORD_W-1] ? n : v;
	endfunction

	function automatic logic [WORD_W-1:0] sat33(input logic [WORD_W:0] v);
		logic [WORD_W-1:0] r;
		if (v[WORD_W] != v[WORD_W-1]) begin
			r = v[WORD_W] ? S32_MIN : S32_MAX;
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

### rtl/fsc_ram.sv
`default_nettype none
module fsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/frustum_sphere_cull_top.sv
// Load of columns 0 to 2: the block stays idle and is ready again on the next cycle.
// Load of column 3: rebuilds all six planes; a one-bit-a-cycle square root and divider
// normalize each plane, and the input side stays closed until the rebuild is done.
// Sphere test: six plane reads, one a cycle; the result is valid once the pipeline drains.
// One item is in work at a time. Reset (arst_n low) clears the control state and the
// valid bits of both stores, so that the matrix and planes read as zero until written.
`default_nettype none
module frustum_sphere_cull_top #(
	parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        operation,
	input  wire logic [1:0]                  column,
	input  wire logic [fsc_pkg::WORD_W-1:0]  val_x,
	input  wire logic [fsc_pkg::WORD_W-1:0]  val_y,
	input  wire logic [fsc_pkg::WORD_W-1:0]  val_z,
	input  wire logic [fsc_pkg::WORD_W-1:0]  val_w,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             inside_res
);
	import fsc_pkg::*;

	localparam int W   = WORD_W;
	localparam int DW  = W + FRAC_BITS;
	localparam int DCW = $clog2(DW);

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_RRD    = 13'b0000000000010,
		S_RCAP   = 13'b0000000000100,
		S_RMUL   = 13'b0000000001000,
		S_RACC   = 13'b0000000010000,
		S_RSQRT  = 13'b0000000100000,
		S_RDINI  = 13'b0000001000000,
		S_RDIV   = 13'b0000010000000,
		S_RDSAT  = 13'b0000100000000,
		S_RWR    = 13'b0001000000000,
		S_TRUN   = 13'b0010000000000,
		S_TDRAIN = 13'b0100000000000,
		S_TDONE  = 13'b1000000000000
	} state_t;

	state_t state_q;
	logic [2:0] p_q;
	logic [1:0] c_q;
	logic [NUM_COLS-1:0]   mat_vld_q;
	logic [NUM_PLANES-1:0] pl_vld_q;
	logic mv_q, pv_s1, v_s1, v_s2, reject_q, out_valid_q, inside_q;

	logic signed [W-1:0] px_q, py_q, pz_q, negr_q;
	logic [W-1:0] comp_q [NUM_COLS];
	logic [W-1:0] quot_q [NUM_COLS];
	logic [63:0] prod_q, acc_q, sq_n_q;
	logic [33:0] sq_rem_q;
	logic [W-1:0] sq_root_q;
	logic [4:0] sq_cnt_q;
	logic [W-1:0] div_rem_q;
	logic [DW-1:0] div_num_q, div_quo_q;
	logic [DCW-1:0] div_cnt_q;
	logic signed [63:0] prod_x_s2, prod_y_s2, prod_z_s2;
	logic signed [W-1:0] d_s2;

	logic in_acc;
	logic [4*W-1:0] mat_rdata, pl_rdata, mat_word, pl_word;
	logic [W-1:0] sel_val, w_val, comp_val, kmag, q_sat;
	logic [W:0] pl_sum;
	logic sub_sel;
	logic [35:0] sq_rem_nx, sq_trial;
	logic [W:0] div_rem_nx;
	logic div_ge;
	logic signed [65:0] dist_sum;
	logic signed [W-1:0] dist_sat;

	assign in_ready   = (state_q == S_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;

	fsc_ram #(.WIDTH(4 * W), .DEPTH(NUM_COLS)) u_mat_ram (
		.clk   (clk),
		.we    (in_acc && operation == OP_LOAD),
		.waddr (column),
		.wdata ({val_w, val_z, val_y, val_x}),
		.raddr (c_q),
		.rdata (mat_rdata)
	);

	fsc_ram #(.WIDTH(4 * W), .DEPTH(NUM_PLANES)) u_pl_ram (
		.clk   (clk),
		.we    (state_q == S_RWR),
		.waddr (p_q),
		.wdata ({quot_q[3], quot_q[2], quot_q[1], quot_q[0]}),
		.raddr (p_q),
		.rdata (pl_rdata)
	);

	assign mat_word = mv_q ? mat_rdata : '0;
	assign pl_word  = pv_s1 ? pl_rdata : '0;

	always_comb begin
		unique case (p_q)
			3'd0, 3'd1: sel_val = mat_word[W-1:0];
			3'd2, 3'd3: sel_val = mat_word[2*W-1:W];
			default:    sel_val = mat_word[3*W-1:2*W];
		endcase
		sub_sel  = (p_q == 3'd1) || (p_q == 3'd2) || (p_q == 3'd5);
		w_val    = mat_word[4*W-1:3*W];
		pl_sum   = sub_sel ? ({w_val[W-1], w_val} - {sel_val[W-1], sel_val})
		                   : ({w_val[W-1], w_val} + {sel_val[W-1], sel_val});
		comp_val = sat33(pl_sum);
		kmag     = mag32(comp_q[c_q]);

		sq_rem_nx = {sq_rem_q, sq_n_q[63:62]};
		sq_trial  = {2'b00, sq_root_q, 2'b01};

		div_rem_nx = {div_rem_q, div_num_q[DW-1]};
		div_ge     = (div_rem_nx >= {1'b0, sq_root_q});

		if (comp_q[c_q][W-1]) begin
			q_sat = (div_quo_q > DW'(S32_MIN)) ? S32_MIN : W'(~div_quo_q[W-1:0] + 1'b1);
		end else begin
			q_sat = (div_quo_q > DW'(S32_MAX)) ? S32_MAX : div_quo_q[W-1:0];
		end

		dist_sum = 66'(prod_x_s2 >>> FRAC_BITS) + 66'(prod_y_s2 >>> FRAC_BITS)
		         + 66'(prod_z_s2 >>> FRAC_BITS) + 66'(d_s2);
		if (dist_sum > $signed({34'd0, S32_MAX})) begin
			dist_sat = S32_MAX;
		end else if (dist_sum < $signed({{34{1'b1}}, S32_MIN})) begin
			dist_sat = S32_MIN;
		end else begin
			dist_sat = dist_sum[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			p_q         <= '0;
			c_q         <= '0;
			mat_vld_q   <= '0;
			pl_vld_q    <= '0;
			mv_q        <= 1'b0;
			pv_s1       <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			reject_q    <= 1'b0;
			out_valid_q <= 1'b0;
			sq_cnt_q    <= '0;
			div_cnt_q   <= '0;
		end else begin
			mv_q  <= mat_vld_q[c_q];
			pv_s1 <= pl_vld_q[p_q];
			v_s1  <= (state_q == S_TRUN);
			v_s2  <= v_s1;
			if (v_s2 && dist_sat <= negr_q) begin
				reject_q <= 1'b1;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						p_q <= '0;
						c_q <= '0;
						if (operation == OP_LOAD) begin
							mat_vld_q[column] <= 1'b1;
							if (column == COL_LAST) begin
								state_q <= S_RRD;
							end
						end else begin
							reject_q <= 1'b0;
							state_q  <= S_TRUN;
						end
					end
				end
				S_RRD: state_q <= S_RCAP;
				S_RCAP: begin
					if (c_q == COL_LAST) begin
						c_q     <= '0;
						state_q <= S_RMUL;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= S_RRD;
					end
				end
				S_RMUL: state_q <= S_RACC;
				S_RACC: begin
					if (c_q == 2'd2) begin
						c_q      <= '0;
						sq_cnt_q <= '0;
						state_q  <= S_RSQRT;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= S_RMUL;
					end
				end
				S_RSQRT: begin
					sq_cnt_q <= sq_cnt_q + 5'd1;
					if (sq_cnt_q == 5'(SQ_STEPS - 1)) begin
						state_q <= S_RDINI;
					end
				end
				S_RDINI: begin
					div_cnt_q <= '0;
					state_q   <= (sq_root_q == '0) ? S_RWR : S_RDIV;
				end
				S_RDIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DCW'(DW - 1)) begin
						state_q <= S_RDSAT;
					end
				end
				S_RDSAT: begin
					if (c_q == COL_LAST) begin
						c_q     <= '0;
						state_q <= S_RWR;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= S_RDINI;
					end
				end
				S_RWR: begin
					pl_vld_q[p_q] <= 1'b1;
					c_q           <= '0;
					if (p_q == 3'(NUM_PLANES - 1)) begin
						p_q     <= '0;
						state_q <= S_IDLE;
					end else begin
						p_q     <= p_q + 3'd1;
						state_q <= S_RRD;
					end
				end
				S_TRUN: begin
					if (p_q == 3'(NUM_PLANES - 1)) begin
						p_q     <= '0;
						state_q <= S_TDRAIN;
					end else begin
						p_q <= p_q + 3'd1;
					end
				end
				S_TDRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= S_TDONE;
					end
				end
				S_TDONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && operation == OP_TEST) begin
			px_q   <= val_x;
			py_q   <= val_y;
			pz_q   <= val_z;
			negr_q <= (val_w == S32_MIN) ? S32_MAX : W'(~val_w + 1'b1);
		end
		if (state_q == S_RCAP) begin
			comp_q[c_q] <= comp_val;
		end
		if (state_q == S_RCAP && c_q == COL_LAST) begin
			acc_q <= '0;
		end
		if (state_q == S_RMUL) begin
			prod_q <= kmag * kmag;
		end
		if (state_q == S_RACC) begin
			acc_q     <= acc_q + prod_q;
			sq_n_q    <= acc_q + prod_q;
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end
		if (state_q == S_RSQRT) begin
			sq_n_q <= {sq_n_q[61:0], 2'b00};
			if (sq_rem_nx >= sq_trial) begin
				sq_rem_q  <= 34'(sq_rem_nx - sq_trial);
				sq_root_q <= {sq_root_q[W-2:0], 1'b1};
			end else begin
				sq_rem_q  <= sq_rem_nx[33:0];
				sq_root_q <= {sq_root_q[W-2:0], 1'b0};
			end
		end
		if (state_q == S_RDINI) begin
			div_num_q <= {kmag, {FRAC_BITS{1'b0}}};
			div_rem_q <= '0;
			div_quo_q <= '0;
			if (sq_root_q == '0) begin
				for (int k = 0; k < NUM_COLS; k++) begin
					quot_q[k] <= '0;
				end
			end
		end
		if (state_q == S_RDIV) begin
			div_num_q <= {div_num_q[DW-2:0], 1'b0};
			div_quo_q <= {div_quo_q[DW-2:0], div_ge};
			div_rem_q <= div_ge ? W'(div_rem_nx - {1'b0, sq_root_q}) : div_rem_nx[W-1:0];
		end
		if (state_q == S_RDSAT) begin
			quot_q[c_q] <= q_sat;
		end
		prod_x_s2 <= $signed(pl_word[W-1:0]) * px_q;
		prod_y_s2 <= $signed(pl_word[2*W-1:W]) * py_q;
		prod_z_s2 <= $signed(pl_word[3*W-1:2*W]) * pz_q;
		d_s2      <= $signed(pl_word[4*W-1:3*W]);
		if (state_q == S_TDONE && (!out_valid_q || out_ready)) begin
			inside_q <= !reject_q;
		end
	end
endmodule
`default_nettype wire

### rtl/fsc_checker.sv
`default_nettype none
`include "frustum_sphere_cull_top_macros.svh"
module fsc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       operation,
	input wire logic [1:0] column,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       inside_res
);
	import fsc_pkg::*;

	// A sphere test closes the input side on the next cycle.
	`FSC_NEXT(a_test_busy, in_valid && in_ready && operation == OP_TEST, !in_ready)
	// A plane rebuild also closes the input side.
	`FSC_NEXT(a_rebuild_busy, in_valid && in_ready && operation == OP_LOAD && column == COL_LAST, !in_ready)
	// A plain column load finishes at once.
	`FSC_NEXT(a_load_short, in_valid && in_ready && operation == OP_LOAD && column != COL_LAST, in_ready)
	// A new result appears only as the block returns to idle.
	`FSC_SAME(a_result_idle, $rose(out_valid), in_ready)
	`FSC_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(inside_res))
endmodule

bind frustum_sphere_cull_top fsc_checker u_fsc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.operation  (operation),
	.column     (column),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.inside_res (inside_res)
);
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import fsc_pkg::*;

	typedef struct {
		logic        op;
		logic [1:0]  col;
		logic [31:0] x, y, z, w;
	} cull_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = OP_LOAD;
	logic [1:0]  column = 2'd0;
	logic [31:0] val_x = '0, val_y = '0, val_z = '0, val_w = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        inside_res;

	cull_item_t  pending_items[$];
	logic        expected_inside[$];
	logic [31:0] mtx[16];
	logic [31:0] planes[24];
	int          errors = 0;
	int          cycles = 0;
	int          send_gap = 0;
	int          recv_gap = 0;
	bit          send_burst = 0;

	frustum_sphere_cull_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .column(column),
		.val_x(val_x), .val_y(val_y), .val_z(val_z), .val_w(val_w),
		.out_valid(out_valid), .out_ready(out_ready), .inside_res(inside_res)
	);

	always #10 clk = ~clk;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] n);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic rebuild_planes();
		longint pl[6][4];
		longint x, y, z, w, q;
		logic [63:0] sq, len, m, qm;
		for (int c = 0; c < 4; c++) begin
			x = longint'(signed'(mtx[c*4+0]));
			y = longint'(signed'(mtx[c*4+1]));
			z = longint'(signed'(mtx[c*4+2]));
			w = longint'(signed'(mtx[c*4+3]));
			pl[0][c] = clamp32(w + x);
			pl[1][c] = clamp32(w - x);
			pl[2][c] = clamp32(w - y);
			pl[3][c] = clamp32(w + y);
			pl[4][c] = clamp32(w + z);
			pl[5][c] = clamp32(w - z);
		end
		for (int p = 0; p < 6; p++) begin
			sq = 0;
			for (int k = 0; k < 3; k++) begin
				m = pl[p][k] < 0 ? 64'(-pl[p][k]) : 64'(pl[p][k]);
				sq = sq + m * m;
			end
			len = root_floor(sq);
			for (int k = 0; k < 4; k++) begin
				if (len == 0) begin
					q = 0;
				end else begin
					m = pl[p][k] < 0 ? 64'(-pl[p][k]) : 64'(pl[p][k]);
					qm = (m << 16) / len;
					if (pl[p][k] < 0)
						q = qm > 64'h8000_0000 ? -64'sd2147483648 : -longint'(qm);
					else
						q = qm > 64'h7fff_ffff ? 64'sd2147483647 : longint'(qm);
				end
				planes[p*4+k] = q[31:0];
			end
		end
	endtask

	task automatic predict_transfer(cull_item_t it);
		longint px, py, pz, neg_r, d;
		logic res;
		if (it.op == OP_LOAD) begin
			mtx[it.col*4+0] = it.x;
			mtx[it.col*4+1] = it.y;
			mtx[it.col*4+2] = it.z;
			mtx[it.col*4+3] = it.w;
			if (it.col == COL_LAST) rebuild_planes();
		end else begin
			px = longint'(signed'(it.x));
			py = longint'(signed'(it.y));
			pz = longint'(signed'(it.z));
			neg_r = clamp32(-longint'(signed'(it.w)));
			res = 1'b1;
			for (int p = 0; p < 6; p++) begin
				d = ((longint'(signed'(planes[p*4+0])) * px) >>> 16)
				  + ((longint'(signed'(planes[p*4+1])) * py) >>> 16)
				  + ((longint'(signed'(planes[p*4+2])) * pz) >>> 16)
				  + longint'(signed'(planes[p*4+3]));
				if (res && clamp32(d) <= neg_r) res = 1'b0;
			end
			expected_inside.push_back(res);
		end
	endtask

	function automatic logic [31:0] mat_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return 32'($signed($urandom_range(0, 262144)) - 131072);
		if (r < 85) return $urandom();
		if (r < 90) return S32_MAX;
		if (r < 95) return S32_MIN;
		return 32'd0;
	endfunction

	function automatic logic [31:0] pos_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return 32'($signed($urandom_range(0, 1048576)) - 524288);
		if (r < 93) return $urandom();
		if (r < 97) return S32_MAX;
		return S32_MIN;
	endfunction

	task automatic add_item(logic op, logic [1:0] col, logic [31:0] x, y, z, w);
		cull_item_t it;
		it.op = op; it.col = col; it.x = x; it.y = y; it.z = z; it.w = w;
		pending_items.push_back(it);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("FAIL frustum_sphere_cull_top");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if ($urandom_range(0, 63) == 0) send_burst <= !send_burst;
			if (send_gap > 0 && !send_burst) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				cull_item_t it;
				it = pending_items.pop_front();
				operation <= it.op;
				column <= it.col;
				val_x <= it.x;
				val_y <= it.y;
				val_z <= it.z;
				val_w <= it.w;
				in_valid <= 1'b1;
				send_gap <= gap_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) recv_gap <= gap_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				cull_item_t it;
				it.op = operation; it.col = column;
				it.x = val_x; it.y = val_y; it.z = val_z; it.w = val_w;
				predict_transfer(it);
			end
			if (out_valid && out_ready) begin
				if (expected_inside.size() == 0) begin
					$display("%0t: unexpected result transfer: expected none, actual %0b",
						$time, inside_res);
					errors++;
				end else begin
					logic e;
					e = expected_inside.pop_front();
					if (inside_res !== e) begin
						$display("%0t: inside_res mismatch: expected %0b, actual %0b",
							$time, e, inside_res);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int n;
		foreach (mtx[i]) mtx[i] = '0;
		foreach (planes[i]) planes[i] = '0;
		// Tests against the all-zero reset planes.
		add_item(OP_TEST, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		add_item(OP_TEST, 2'd3, S32_MAX, S32_MIN, 32'd5, 32'hffff_0000);
		add_item(OP_TEST, 2'd1, 32'd1, 32'd2, 32'd3, 32'h0001_0000);
		add_item(OP_TEST, 2'd2, S32_MIN, S32_MAX, S32_MIN, S32_MIN);
		add_item(OP_TEST, 2'd0, 32'd0, 32'd0, 32'd0, S32_MAX);
		// Zero matrix rebuild gives zero-length normals.
		add_item(OP_LOAD, 2'd3, 32'd0, 32'd0, 32'd0, 32'd0);
		add_item(OP_TEST, 2'd0, 32'd7, 32'd7, 32'd7, 32'd1);
		// Identity matrix.
		add_item(OP_LOAD, 2'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0);
		add_item(OP_LOAD, 2'd1, 32'd0, 32'h0001_0000, 32'd0, 32'd0);
		add_item(OP_LOAD, 2'd2, 32'd0, 32'd0, 32'h0001_0000, 32'd0);
		add_item(OP_TEST, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		add_item(OP_LOAD, 2'd3, 32'd0, 32'd0, 32'd0, 32'h0001_0000);
		add_item(OP_TEST, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		add_item(OP_TEST, 2'd0, 32'h0003_0000, 32'd0, 32'd0, 32'h0001_0000);
		add_item(OP_TEST, 2'd0, 32'h0002_0000, 32'd0, 32'd0, 32'h0001_0000);
		add_item(OP_TEST, 2'd0, 32'd0, 32'hfffe_0000, 32'd0, 32'hffff_0000);
		add_item(OP_TEST, 2'd0, S32_MAX, S32_MAX, S32_MAX, S32_MIN);
		add_item(OP_TEST, 2'd0, S32_MIN, S32_MIN, S32_MIN, S32_MAX);
		// Saturating matrix: sums and differences overflow.
		add_item(OP_LOAD, 2'd0, S32_MAX, S32_MIN, S32_MAX, S32_MAX);
		add_item(OP_LOAD, 2'd1, S32_MIN, S32_MAX, S32_MIN, S32_MIN);
		add_item(OP_LOAD, 2'd2, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		add_item(OP_LOAD, 2'd3, S32_MIN, S32_MAX, S32_MIN, S32_MAX);
		add_item(OP_TEST, 2'd0, 32'h0000_8000, 32'hffff_8000, 32'd1, 32'h0000_0001);
		add_item(OP_TEST, 2'd0, S32_MIN, S32_MAX, 32'd0, 32'd0);
		n = 24;
		while (n < 924) begin
			if ($urandom_range(0, 9) < 8) begin
				for (int c = 0; c < 4; c++)
					add_item(OP_LOAD, 2'(c), mat_word(), mat_word(), mat_word(), mat_word());
				n += 4;
				repeat ($urandom_range(4, 24)) begin
					add_item(OP_TEST, 2'($urandom_range(0, 3)), pos_word(), pos_word(),
						pos_word(), pos_word());
					n++;
				end
			end else begin
				add_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom(),
					$urandom(), $urandom(), $urandom());
				n++;
			end
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_items.size() > 0 || in_valid) @(posedge clk);
		while (expected_inside.size() > 0) @(posedge clk);
		repeat (1500) @(posedge clk);
		if (expected_inside.size() > 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				expected_inside.size());
			errors++;
		end
		if (errors == 0) begin
			$display("PASS frustum_sphere_cull_top");
		end else begin
			$display("FAIL frustum_sphere_cull_top");
		end
		$finish;
	end
endmodule
`default_nettype wire
